// ===== design/u16u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
`default_nettype none
package u16u8_pkg;

	localparam int unsigned MAX_BYTES = 4;

	localparam logic [7:0]  REPLACEMENT_BYTE = 8'h3F;
	localparam logic [5:0]  HIGH_SURR_TAG    = 6'b110110;
	localparam logic [5:0]  LOW_SURR_TAG     = 6'b110111;
	localparam logic [15:0] ONE_BYTE_LIMIT   = 16'h0080;
	localparam logic [15:0] TWO_BYTE_LIMIT   = 16'h0800;
	localparam logic [20:0] SUPP_BASE        = 21'h10000;
	localparam logic [1:0]  CONT_TAG         = 2'b10;
	localparam logic [2:0]  LEAD2_TAG        = 3'b110;
	localparam logic [3:0]  LEAD3_TAG        = 4'b1110;
	localparam logic [4:0]  LEAD4_TAG        = 5'b11110;

	// One classified unit: the bytes it produces, first byte at index 0.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                count;
	} job_t;

endpackage
`default_nettype wire

// ===== design/u16u8_front.sv =====
// Front end: accepts code units, tracks a pending high surrogate and builds byte jobs.
`default_nettype none
module u16u8_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            unit_valid,
	output logic                 unit_stall,
	input  wire logic [15:0]     code_unit,
	input  wire logic            queue_full,
	output logic                 push,
	output u16u8_pkg::job_t      push_job
);
	import u16u8_pkg::*;

	logic        pending_q;
	logic [9:0]  pending_bits_q;
	logic        accept;
	logic        is_high;
	logic        is_low;
	logic [20:0] code_point;
	job_t        enc;
	job_t        job;
	logic        pending_d;
	logic [9:0]  pending_bits_d;

	assign unit_stall = queue_full;
	assign accept     = unit_valid && !queue_full;
	assign is_high    = (code_unit[15:10] == HIGH_SURR_TAG);
	assign is_low     = (code_unit[15:10] == LOW_SURR_TAG);
	assign code_point = SUPP_BASE + {1'b0, pending_bits_q, code_unit[9:0]};

	// Plain encoding of a non-surrogate unit.
	always_comb begin
		enc = '0;
		if (code_unit < ONE_BYTE_LIMIT) begin
			enc.bytes[0] = code_unit[7:0];
			enc.count    = 3'd1;
		end else if (code_unit < TWO_BYTE_LIMIT) begin
			enc.bytes[0] = {LEAD2_TAG, code_unit[10:6]};
			enc.bytes[1] = {CONT_TAG, code_unit[5:0]};
			enc.count    = 3'd2;
		end else begin
			enc.bytes[0] = {LEAD3_TAG, code_unit[15:12]};
			enc.bytes[1] = {CONT_TAG, code_unit[11:6]};
			enc.bytes[2] = {CONT_TAG, code_unit[5:0]};
			enc.count    = 3'd3;
		end
	end

	always_comb begin
		job            = '0;
		pending_d      = pending_q;
		pending_bits_d = pending_bits_q;
		if (code_unit == '0) begin
			if (pending_q) begin
				job.bytes[0] = REPLACEMENT_BYTE;
				job.count    = 3'd1;
			end
			pending_d      = 1'b0;
			pending_bits_d = '0;
		end else if (is_low) begin
			if (pending_q) begin
				job.bytes[0]   = {LEAD4_TAG, code_point[20:18]};
				job.bytes[1]   = {CONT_TAG, code_point[17:12]};
				job.bytes[2]   = {CONT_TAG, code_point[11:6]};
				job.bytes[3]   = {CONT_TAG, code_point[5:0]};
				job.count      = 3'd4;
				pending_d      = 1'b0;
				pending_bits_d = '0;
			end else begin
				job.bytes[0] = REPLACEMENT_BYTE;
				job.count    = 3'd1;
			end
		end else if (is_high) begin
			// An orphaned earlier high surrogate is flagged, the new one is held.
			if (pending_q) begin
				job.bytes[0] = REPLACEMENT_BYTE;
				job.count    = 3'd1;
			end
			pending_d      = 1'b1;
			pending_bits_d = code_unit[9:0];
		end else begin
			if (pending_q) begin
				job.bytes[0] = REPLACEMENT_BYTE;
				job.bytes[1] = enc.bytes[0];
				job.bytes[2] = enc.bytes[1];
				job.bytes[3] = enc.bytes[2];
				job.count    = enc.count + 3'd1;
			end else begin
				job = enc;
			end
			pending_d      = 1'b0;
			pending_bits_d = '0;
		end
	end

	assign push     = accept && (job.count != 3'd0);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q      <= 1'b0;
			pending_bits_q <= '0;
		end else if (accept) begin
			pending_q      <= pending_d;
			pending_bits_q <= pending_bits_d;
		end
	end
endmodule
`default_nettype wire

// ===== design/u16u8_queue.sv =====
// Small job queue between the front end and the byte serializer.
`default_nettype none
module u16u8_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire u16u8_pkg::job_t push_job,
	input  wire logic            pop,
	output logic                 full,
	output logic                 empty,
	output u16u8_pkg::job_t      head_job
);
	import u16u8_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          slots_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign full     = (fill_q == CW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign head_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/u16u8_back.sv =====
// Back end: serializes queued jobs into one output byte per transaction.
`default_nettype none
module u16u8_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            queue_empty,
	input  wire u16u8_pkg::job_t head_job,
	output logic                 pop,
	output logic                 byte_valid,
	input  wire logic            byte_stall,
	output logic [7:0]           out_byte,
	output logic                 last_of_run
);
	import u16u8_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       load;
	logic       is_last;

	// The output register refills whenever the queue holds a job and the register is empty or being taken.
	assign load    = !queue_empty && (!valid_q || !byte_stall);
	assign is_last = ({1'b0, idx_q} == (head_job.count - 3'd1));
	assign pop     = load && is_last;

	assign byte_valid  = valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head_job.bytes[idx_q];
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? '0 : idx_q + 1'b1;
			end else if (!byte_stall) begin
				valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder.
`default_nettype none
// Takes one UTF-16 code unit per transaction and gives UTF-8 bytes, one per
// transaction, with last_of_run marking the final byte a unit caused. A unit
// gives zero to four bytes; a high surrogate or a zero unit with nothing
// pending gives none. A unit is accepted in any cycle in which the job queue has
// room, so input runs at one unit per cycle until the output side falls behind;
// sustained throughput is one output byte per cycle while byte_stall is low, set
// by the byte serializer. The first byte of a unit is written into the job queue
// and then into the output register before it is driven on the output.
module utf16_to_utf8_transcoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        unit_valid,
	output logic             unit_stall,
	input  wire logic [15:0] code_unit,
	output logic             byte_valid,
	input  wire logic        byte_stall,
	output logic [7:0]       out_byte,
	output logic             last_of_run
);
	import u16u8_pkg::*;

	logic queue_full;
	logic queue_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head_job;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.code_unit  (code_unit),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (queue_full),
		.empty    (queue_empty),
		.head_job (head_job)
	);

	u16u8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head_job    (head_job),
		.pop         (pop),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);
endmodule
`default_nettype wire

// ===== sim/utf16_to_utf8_transcoder_tb.sv =====
// Self-checking testbench for the UTF-16 to UTF-8 transcoder.
module utf16_to_utf8_transcoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import u16u8_pkg::*;

	localparam int RANDOM_UNITS = 420;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 20;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} utf8_byte_t;

	// Tracks surrogate state, predicts the bytes of each accepted code unit and
	// compares every delivered byte against the oldest prediction.
	class utf8_scoreboard;
		bit         surrogate_held;
		logic [9:0] held_bits;
		utf8_byte_t expected_bytes[$];
		logic [7:0] burst[MAX_BYTES];
		int         burst_len;
		int         errors;
		int         units;
		int         bytes_seen;
		int         supp_points;
		int         replacements;

		function void emit_byte(logic [7:0] b);
			burst[burst_len] = b;
			burst_len++;
		endfunction

		function void emit_replacement();
			emit_byte(REPLACEMENT_BYTE);
			replacements++;
		endfunction

		function void note_unit(logic [15:0] cu);
			logic [20:0] cp;
			bit          is_high;
			bit          is_low;
			utf8_byte_t  entry;
			is_high = (cu[15:10] == HIGH_SURR_TAG);
			is_low  = (cu[15:10] == LOW_SURR_TAG);
			burst_len = 0;
			units++;
			if (cu == 16'h0000) begin
				if (surrogate_held)
					emit_replacement();
				surrogate_held = 1'b0;
				held_bits = '0;
			end else if (is_low) begin
				if (surrogate_held) begin
					cp = SUPP_BASE + {1'b0, held_bits, cu[9:0]};
					emit_byte({LEAD4_TAG, cp[20:18]});
					emit_byte({CONT_TAG, cp[17:12]});
					emit_byte({CONT_TAG, cp[11:6]});
					emit_byte({CONT_TAG, cp[5:0]});
					surrogate_held = 1'b0;
					held_bits = '0;
					supp_points++;
				end else begin
					emit_replacement();
				end
			end else begin
				// An orphaned high surrogate is replaced before the new unit is encoded.
				if (surrogate_held) begin
					emit_replacement();
					surrogate_held = 1'b0;
					held_bits = '0;
				end
				if (is_high) begin
					surrogate_held = 1'b1;
					held_bits = cu[9:0];
				end else if (cu < ONE_BYTE_LIMIT) begin
					emit_byte(cu[7:0]);
				end else if (cu < TWO_BYTE_LIMIT) begin
					emit_byte({LEAD2_TAG, cu[10:6]});
					emit_byte({CONT_TAG, cu[5:0]});
				end else begin
					emit_byte({LEAD3_TAG, cu[15:12]});
					emit_byte({CONT_TAG, cu[11:6]});
					emit_byte({CONT_TAG, cu[5:0]});
				end
			end
			for (int i = 0; i < burst_len; i++) begin
				entry.value = burst[i];
				entry.last = (i == burst_len - 1);
				expected_bytes.insert(expected_bytes.size(), entry);
			end
		endfunction

		function void check_byte(logic [7:0] value, logic last);
			utf8_byte_t want;
			bytes_seen++;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte: expected none, actual out_byte=%02h last_of_run=%0b",
					$time, value, last);
				errors++;
				return;
			end
			want = expected_bytes.pop_front();
			if (value !== want.value) begin
				$display("%0t: out_byte mismatch: expected %02h, actual %02h",
					$time, want.value, value);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: last_of_run mismatch: expected %0b, actual %0b",
					$time, want.last, last);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_bytes.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        unit_valid;
	logic        unit_stall;
	logic [15:0] code_unit;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  out_byte;
	logic        last_of_run;

	utf8_scoreboard sb = new;

	bit idling;
	bit hold_off_req;
	int input_stall_cycles;
	int longest_input_stall;

	utf16_to_utf8_transcoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.code_unit  (code_unit),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 0;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout after %0d cycles, %0d bytes still expected",
			$time, cycles, sb.outstanding());
		$display("*** FAILED ***");
		$finish;
	end

	// Output side: random stall bursts, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		byte_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (idling && stall_left == 0 && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 11);
			end
			if (stall_left > 0) begin
				byte_stall <= 1'b1;
				stall_left--;
			end else begin
				byte_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall)
			sb.check_byte(out_byte, last_of_run);
	end

	// Offers one code unit, holds it until accepted, then maybe idles a while.
	// Called and returns at a falling edge; valid stays high between back-to-back units.
	task automatic push_unit(input logic [15:0] cu);
		int stalled;
		unit_valid <= 1'b1;
		code_unit <= cu;
		stalled = 0;
		@(posedge clk);
		while (unit_stall) begin
			stalled++;
			@(posedge clk);
		end
		sb.note_unit(cu);
		input_stall_cycles += stalled;
		if (stalled > longest_input_stall)
			longest_input_stall = stalled;
		@(negedge clk);
		if (idling && $urandom_range(0, 4) == 0) begin
			unit_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		unit_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	// Sends one random unit, or a well-formed surrogate pair; returns units sent.
	task automatic push_random(output int sent);
		int pick;
		pick = $urandom_range(0, 99);
		sent = 1;
		if (pick < 20) begin
			push_unit(16'($urandom_range(1, 16'h007F)));
		end else if (pick < 35) begin
			push_unit(16'($urandom_range(16'h0080, 16'h07FF)));
		end else if (pick < 50) begin
			if ($urandom_range(0, 1))
				push_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
			else
				push_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
		end else if (pick < 78) begin
			push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
			push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
			sent = 2;
		end else if (pick < 84) begin
			push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
		end else if (pick < 90) begin
			push_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
		end else if (pick < 94) begin
			push_unit(16'h0000);
		end else begin
			push_unit(16'($urandom()));
		end
	endtask

	initial begin
		int random_sent;
		int sent;
		int chunk;
		arst_n = 1'b0;
		unit_valid = 1'b0;
		code_unit = '0;
		idling = 1'b1;
		hold_off_req = 1'b0;
		input_stall_cycles = 0;
		longest_input_stall = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Field extremes and the byte-count boundaries.
		push_unit(16'h0041);
		push_unit(16'h0001);
		push_unit(16'h007F);
		push_unit(16'h0080);
		push_unit(16'h07FF);
		push_unit(16'h0800);
		push_unit(16'hD7FF);
		push_unit(16'hE000);
		push_unit(16'hFFFF);
		// Surrogate pairs at both ends of the supplementary range.
		push_unit(16'hD800);
		push_unit(16'hDC00);
		push_unit(16'hDBFF);
		push_unit(16'hDFFF);
		// Low surrogates with nothing pending.
		push_unit(16'hDC00);
		push_unit(16'hDFFF);
		// A high surrogate orphaned by a plain unit, then by another high surrogate.
		push_unit(16'hD800);
		push_unit(16'h0041);
		push_unit(16'hDABC);
		push_unit(16'hDB01);
		push_unit(16'hDE02);
		// End of string with and without a pending surrogate.
		push_unit(16'hD912);
		push_unit(16'h0000);
		push_unit(16'h0000);
		push_unit(16'hD800);
		push_unit(16'hFFFF);
		wait_drained();
		@(negedge clk);

		random_sent = 0;
		chunk = 0;
		while (random_sent < RANDOM_UNITS) begin
			if (random_sent / 40 != chunk) begin
				chunk = random_sent / 40;
				idling = ($urandom_range(0, 3) != 0);
			end
			// The last stretch of the run goes at full speed.
			if (random_sent >= RANDOM_UNITS - 60)
				idling = 1'b0;
			if (chunk == 5 && hold_off_req == 1'b0 && random_sent % 40 < 2) begin
				// Long output hold-off while the input keeps offering, then a full drain.
				idling = 1'b0;
				hold_off_req = 1'b1;
				repeat (40) begin
					push_random(sent);
					random_sent += sent;
				end
				wait_drained();
				@(negedge clk);
				chunk = random_sent / 40;
			end
			push_random(sent);
			random_sent += sent;
		end

		unit_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d code units, %0d bytes checked, %0d supplementary code points,",
			sb.units, sb.bytes_seen, sb.supp_points);
		$display("%0d replacement bytes; input held back %0d cycles, longest %0d in a row.",
			sb.replacements, input_stall_cycles, longest_input_stall);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
